// ===== rtl/voxel_cell_classifier_top_defines.svh =====
// assertion macros for the voxel cell classifier checker
// no dependencies
`ifndef VOXEL_CELL_CLASSIFIER_TOP_DEFINES_SVH
`define VOXEL_CELL_CLASSIFIER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define VCC_ASSERT_IMP(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// plain assertion that also holds during reset
`define VCC_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

// ===== rtl/vcc_pkg.sv =====
// package for the voxel cell classifier: widths, action codes, wedge table
// no dependencies
package vcc_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int COORD_BITS = 10;
    localparam int IDX_BITS   = 12;
    localparam int CNT_BITS   = 13;
    localparam int LC_BITS    = 11;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    // spare code, ignored by the block
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_HEX   = 2'd1;
    localparam logic [1:0] KIND_WEDGE = 2'd2;

    typedef struct packed {
        logic [1:0]            action;
        logic [COORD_BITS-1:0] grid_x;
        logic [COORD_BITS-1:0] grid_y;
        logic [COORD_BITS-1:0] grid_z;
        logic [IDX_BITS-1:0]   point_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          cell_kind;
        logic [IDX_BITS-1:0] corner_a;
        logic [IDX_BITS-1:0] corner_b;
        logic [IDX_BITS-1:0] corner_c;
        logic [IDX_BITS-1:0] corner_d;
        logic [IDX_BITS-1:0] corner_e;
        logic [IDX_BITS-1:0] corner_f;
        logic [IDX_BITS-1:0] corner_g;
        logic [IDX_BITS-1:0] corner_h;
    } t_out_word;

    localparam logic [7:0] WEDGE_MISSING [12] = '{
        8'h03, 8'h30, 8'hC0, 8'h0C, 8'h0A, 8'hA0,
        8'h50, 8'h05, 8'h11, 8'h22, 8'h88, 8'h44
    };
    // six corner numbers, first corner in the low three bits
    localparam logic [17:0] WEDGE_ORDER [12] = '{
        {3'd6, 3'd2, 3'd4, 3'd7, 3'd3, 3'd5},
        {3'd2, 3'd0, 3'd6, 3'd3, 3'd1, 3'd7},
        {3'd4, 3'd2, 3'd0, 3'd5, 3'd3, 3'd1},
        {3'd4, 3'd6, 3'd0, 3'd5, 3'd7, 3'd1},
        {3'd6, 3'd7, 3'd2, 3'd4, 3'd5, 3'd0},
        {3'd6, 3'd3, 3'd2, 3'd4, 3'd1, 3'd0},
        {3'd7, 3'd3, 3'd2, 3'd5, 3'd1, 3'd0},
        {3'd7, 3'd3, 3'd6, 3'd5, 3'd1, 3'd4},
        {3'd7, 3'd5, 3'd6, 3'd3, 3'd1, 3'd2},
        {3'd6, 3'd7, 3'd4, 3'd2, 3'd3, 3'd0},
        {3'd2, 3'd1, 3'd0, 3'd6, 3'd5, 3'd4},
        {3'd3, 3'd1, 3'd0, 3'd7, 3'd5, 3'd4}
    };
endpackage

// ===== rtl/vcc_if.sv =====
// valid/ready channel interfaces for the voxel cell classifier
// depends on vcc_pkg
interface vcc_in_if import vcc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vcc_out_if import vcc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vcc_cfg_if import vcc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LC_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/voxel_cell_classifier_top.sv =====
// A query walks the point store one entry per cycle through a single read port and one
// compare unit: a first pass over the N stored points finds the layer runs, a second pass
// (a lead-in step, then N entries) matches the eight corners, and the result word is
// registered in S_FIN and offered once S_OUT sets the output valid.
// Loads and clears can follow back to back. The block takes no word while a query runs
// or a result waits.
// depends on vcc_pkg and vcc_if
module voxel_cell_classifier_top import vcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vcc_cfg_if.sink   cfg,
    vcc_in_if.sink    in_ch,
    vcc_out_if.source out_ch
);
    localparam logic [2:0] S_IDLE = 3'd0, S_QRD = 3'd1, S_QCHK = 3'd2, S_RUN = 3'd3,
                           S_CRN = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6;
    localparam logic [1:0] RUN_NONE = 2'd0, RUN_OPEN = 2'd1, RUN_DONE = 2'd2;
    localparam int PW = 3 * COORD_BITS;

    logic [PW-1:0] mem [MAX_POINTS];
    logic [PW-1:0] r_rd;
    logic [IDX_BITS-1:0] rd_addr;

    logic [2:0]          r_st, n_st;
    logic [CNT_BITS-1:0] r_cnt;
    logic [LC_BITS-1:0]  r_lc;
    logic [IDX_BITS-1:0] r_q;
    logic [CNT_BITS-1:0] r_i;      // index of entry in r_rd
    logic [COORD_BITS-1:0] r_x, r_y, r_z;
    // run tracking: not seen, in run, run closed
    logic [1:0] r_r0, r_r1;
    logic r_qin;
    logic [7:0] r_pres;
    logic [IDX_BITS-1:0] r_p [8];
    t_out_word r_out;
    logic r_ov;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = (r_st == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    assign rd_addr = (r_st == S_IDLE) ? in_ch.data.point_index : r_i[IDX_BITS-1:0] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready && in_ch.data.action == ACT_LOAD
            && r_cnt < CNT_BITS'(MAX_POINTS)) begin
            mem[r_cnt[IDX_BITS-1:0]] <= {in_ch.data.grid_x, in_ch.data.grid_y,
                                        in_ch.data.grid_z};
        end
        r_rd <= mem[rd_addr];
    end

    logic [COORD_BITS-1:0] ex, ey, ez;
    logic [COORD_BITS:0] x1, y1, z1;
    assign {ex, ey, ez} = r_rd;
    assign x1 = {1'b0, r_x} + 1'b1;
    assign y1 = {1'b0, r_y} + 1'b1;
    assign z1 = {1'b0, r_z} + 1'b1;
    logic in_l0, in_l1, last;
    assign in_l0 = (ex == r_x) && (r_r0 != RUN_DONE);
    assign in_l1 = ({1'b0, ex} == x1) && (r_r1 != RUN_DONE);
    assign last  = (r_i + 1'b1) >= r_cnt;

    // corner slot for the current entry: bit0 z+1, bit1 layer+1, bit2 y+1
    logic ym, yp, zm, zp;
    assign ym = ey == r_y;
    assign yp = {1'b0, ey} == y1;
    assign zm = ez == r_z;
    assign zp = {1'b0, ez} == z1;

    t_out_word wo;
    logic [7:0] miss;
    always_comb begin
        miss = ~r_pres;
        wo = '0;
        if (r_pres == 8'hFF) begin
            wo = '{KIND_HEX, r_p[0], r_p[1], r_p[2], r_p[3], r_p[4], r_p[5], r_p[6], r_p[7]};
        end else begin
            for (int w = 0; w < 12; w++) begin
                if (miss == WEDGE_MISSING[w]) begin
                    wo.cell_kind = KIND_WEDGE;
                    wo.corner_a = r_p[WEDGE_ORDER[w][2:0]];
                    wo.corner_b = r_p[WEDGE_ORDER[w][5:3]];
                    wo.corner_c = r_p[WEDGE_ORDER[w][8:6]];
                    wo.corner_d = r_p[WEDGE_ORDER[w][11:9]];
                    wo.corner_e = r_p[WEDGE_ORDER[w][14:12]];
                    wo.corner_f = r_p[WEDGE_ORDER[w][17:15]];
                end
            end
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (in_ch.valid && in_ch.ready && in_ch.data.action == ACT_QUERY)
                        n_st = S_QRD;
            S_QRD:  n_st = S_QCHK;
            S_QCHK: n_st = S_RUN;
            S_RUN:  n_st = last ? S_CRN : S_RUN;
            S_CRN:  n_st = last ? S_FIN : S_CRN;
            S_FIN:  n_st = S_OUT;
            S_OUT:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_lc <= LC_BITS'(1); r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (cfg.valid && cfg.ready) r_lc <= cfg.data;
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.data.action == ACT_LOAD && r_cnt < CNT_BITS'(MAX_POINTS))
                    r_cnt <= r_cnt + 1'b1;
                else if (in_ch.data.action == ACT_CLEAR)
                    r_cnt <= '0;
            end
            if (r_st == S_OUT) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_q <= in_ch.data.point_index;
                r_i <= {CNT_BITS{1'b1}};   // so that rd_addr runs from entry 0
            end
            S_QRD: begin
                // r_rd holds queried point
                {r_x, r_y, r_z} <= r_rd;
                r_r0 <= RUN_NONE; r_r1 <= RUN_NONE; r_qin <= 1'b0; r_pres <= '0;
            end
            S_QCHK: begin
                // index 0 entry arrives next
                r_i <= r_i + 1'b1;
                r_out <= '0;
            end
            S_RUN: begin
                if (r_i < r_cnt && in_l0 && r_i[IDX_BITS-1:0] == r_q) r_qin <= 1'b1;
                if (last) begin
                    r_r0 <= RUN_NONE; r_r1 <= RUN_NONE;
                    r_i <= {CNT_BITS{1'b1}};
                end else begin
                    if (ex == r_x && r_r0 == RUN_NONE) r_r0 <= RUN_OPEN;
                    else if (ex != r_x && r_r0 == RUN_OPEN) r_r0 <= RUN_DONE;
                    if ({1'b0, ex} == x1 && r_r1 == RUN_NONE) r_r1 <= RUN_OPEN;
                    else if ({1'b0, ex} != x1 && r_r1 == RUN_OPEN) r_r1 <= RUN_DONE;
                    r_i <= r_i + 1'b1;
                end
            end
            S_CRN: begin
                if (r_i < r_cnt) begin
                    if (ex == r_x && r_r0 == RUN_NONE) r_r0 <= RUN_OPEN;
                    else if (ex != r_x && r_r0 == RUN_OPEN) r_r0 <= RUN_DONE;
                    if ({1'b0, ex} == x1 && r_r1 == RUN_NONE) r_r1 <= RUN_OPEN;
                    else if ({1'b0, ex} != x1 && r_r1 == RUN_OPEN) r_r1 <= RUN_DONE;
                    for (int k = 0; k < 8; k++) begin
                        if (!r_pres[k] && (k[1] ? in_l1 : in_l0)
                            && (k[2] ? yp : ym) && (k[0] ? zp : zm)) begin
                            r_pres[k] <= 1'b1;
                            r_p[k] <= r_i[IDX_BITS-1:0];
                        end
                    end
                end
                r_i <= r_i + 1'b1;
            end
            S_FIN: begin
                if ({1'b0, r_q} < r_cnt && {1'b0, x1} < {1'b0, r_lc} && r_qin
                    && r_r1 != RUN_NONE)
                    r_out <= wo;
            end
            S_OUT: ;
            default: ;
        endcase
    end
endmodule

// ===== rtl/vcc_checker.sv =====
// port-level checker for the voxel cell classifier, bound to the top level
// depends on vcc_pkg and voxel_cell_classifier_top_defines.svh
`include "voxel_cell_classifier_top_defines.svh"
module vcc_checker import vcc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid, in_ready,
    input logic out_valid, out_ready,
    input logic [1:0] out_kind
);
    `VCC_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, out_valid |-> !in_ready, "input taken while word waits")
    `VCC_ASSERT_IMP(a_kind_legal, i_clk, i_rst_n, out_valid |-> (out_kind == KIND_NONE || out_kind == KIND_HEX || out_kind == KIND_WEDGE), "bad cell kind")
    `VCC_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
    `VCC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !out_valid, "word after reset")
endmodule

bind voxel_cell_classifier_top vcc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.data.cell_kind)
);

// ===== tb/tb_voxel_cell_classifier_top.sv =====
// testbench for voxel_cell_classifier_top: loads point grids, queries cells and
// checks every result word against a scoreboard with its own cell predictor
// depends on vcc_pkg, vcc_if and the block itself
module tb_voxel_cell_classifier_top;
    import vcc_pkg::*;

    localparam int IN_BITS = $bits(t_in_word);

    // missing corner pair per wedge case, then the six corners in output order
    localparam logic [7:0] MISSING_PAIR [12] = '{
        8'h03, 8'h30, 8'hC0, 8'h0C, 8'h0A, 8'hA0,
        8'h50, 8'h05, 8'h11, 8'h22, 8'h88, 8'h44
    };
    localparam int WEDGE_SEQ [12][6] = '{
        '{5, 3, 7, 4, 2, 6}, '{7, 1, 3, 6, 0, 2}, '{1, 3, 5, 0, 2, 4},
        '{1, 7, 5, 0, 6, 4}, '{0, 5, 4, 2, 7, 6}, '{0, 1, 4, 2, 3, 6},
        '{0, 1, 5, 2, 3, 7}, '{4, 1, 5, 6, 3, 7}, '{2, 1, 3, 6, 5, 7},
        '{0, 3, 2, 4, 7, 6}, '{4, 5, 6, 0, 1, 2}, '{4, 5, 7, 0, 1, 3}
    };

    class cell_scoreboard;
        logic [COORD_BITS-1:0] px [MAX_POINTS];
        logic [COORD_BITS-1:0] py [MAX_POINTS];
        logic [COORD_BITS-1:0] pz [MAX_POINTS];
        int        stored = 0;
        int        layers = 1;
        int        errors = 0;
        t_out_word pending_cells [$];

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // first contiguous run of entries in the given layer
        function bit find_run(int layer, output int first, output int last);
            for (int n = 0; n < stored; n++) begin
                if (px[n] == layer) begin
                    first = n;
                    last  = n;
                    while (last + 1 < stored && px[last + 1] == layer) last++;
                    return 1;
                end
            end
            return 0;
        endfunction

        function int find_corner(int x, int y, int z, int first, int last);
            for (int n = first; n <= last && n < stored; n++)
                if (px[n] == x && py[n] == y && pz[n] == z) return n;
            return -1;
        endfunction

        function t_out_word classify(int q);
            t_out_word r;
            int x, y, z, f0, e0, f1, e1;
            int p [8];
            int c [8];
            logic [7:0] present;
            r = '0;
            if (q >= stored) return r;
            x = int'(px[q]);
            y = int'(py[q]);
            z = int'(pz[q]);
            if (x + 1 >= layers) return r;
            if (!find_run(x, f0, e0) || q < f0 || q > e0) return r;
            if (!find_run(x + 1, f1, e1)) return r;
            p[0] = find_corner(x, y, z, f0, e0);
            p[1] = find_corner(x, y, z + 1, f0, e0);
            p[4] = find_corner(x, y + 1, z, f0, e0);
            p[5] = find_corner(x, y + 1, z + 1, f0, e0);
            p[2] = find_corner(x + 1, y, z, f1, e1);
            p[3] = find_corner(x + 1, y, z + 1, f1, e1);
            p[6] = find_corner(x + 1, y + 1, z, f1, e1);
            p[7] = find_corner(x + 1, y + 1, z + 1, f1, e1);
            for (int k = 0; k < 8; k++) present[k] = (p[k] >= 0);
            c = '{default: 0};
            if (present == 8'hFF) begin
                r.cell_kind = KIND_HEX;
                c = p;
            end else begin
                for (int w = 0; w < 12; w++) begin
                    if (~present == MISSING_PAIR[w]) begin
                        r.cell_kind = KIND_WEDGE;
                        for (int k = 0; k < 6; k++) c[k] = p[WEDGE_SEQ[w][k]];
                    end
                end
            end
            if (r.cell_kind == KIND_NONE) return r;
            r.corner_a = IDX_BITS'(c[0]); r.corner_b = IDX_BITS'(c[1]);
            r.corner_c = IDX_BITS'(c[2]); r.corner_d = IDX_BITS'(c[3]);
            r.corner_e = IDX_BITS'(c[4]); r.corner_f = IDX_BITS'(c[5]);
            r.corner_g = IDX_BITS'(c[6]); r.corner_h = IDX_BITS'(c[7]);
            return r;
        endfunction

        function void note_input(t_in_word w);
            case (w.action)
                ACT_LOAD: begin
                    if (stored < MAX_POINTS) begin
                        px[stored] = w.grid_x;
                        py[stored] = w.grid_y;
                        pz[stored] = w.grid_z;
                        stored++;
                    end
                end
                ACT_CLEAR: stored = 0;
                ACT_QUERY: pending_cells = {pending_cells, classify(int'(w.point_index))};
                default: ;
            endcase
        endfunction

        task check_cell(t_out_word got);
            t_out_word want;
            logic [IDX_BITS-1:0] g [8];
            logic [IDX_BITS-1:0] e [8];
            if (pending_cells.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = pending_cells.pop_front();
            if (got.cell_kind !== want.cell_kind)
                report($sformatf("cell_kind got %0d want %0d", got.cell_kind, want.cell_kind));
            g = '{got.corner_a, got.corner_b, got.corner_c, got.corner_d,
                  got.corner_e, got.corner_f, got.corner_g, got.corner_h};
            e = '{want.corner_a, want.corner_b, want.corner_c, want.corner_d,
                  want.corner_e, want.corner_f, want.corner_g, want.corner_h};
            for (int k = 0; k < 8; k++)
                if (g[k] !== e[k])
                    report($sformatf("corner %0d got %0d want %0d", k, g[k], e[k]));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    vcc_cfg_if cfg_ch ();
    vcc_in_if  in_ch ();
    vcc_out_if out_ch ();

    voxel_cell_classifier_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_ch),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    cell_scoreboard sb = new();
    bit calm      = 0;
    bit hold_req  = 0;
    bit hold_done = 0;
    int items_out = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rand_gap(int lo);
        if ($urandom_range(0, 9) < 8) return $urandom_range(lo, 3);
        return $urandom_range(15, 60);
    endfunction

    // receiver: random stalls, and one long hold-off when asked
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (rand_gap(1)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_cell(out_ch.data);
    end

    task automatic send_word(t_in_word w);
        int gap;
        in_ch.data  <= w;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(w);
        items_out++;
        gap = calm ? 0 : rand_gap(0);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(int x, int y, int z);
        t_in_word w;
        w = '0;
        w.action = ACT_LOAD;
        w.grid_x = COORD_BITS'(x); w.grid_y = COORD_BITS'(y); w.grid_z = COORD_BITS'(z);
        w.point_index = IDX_BITS'($urandom());
        send_word(w);
    endtask

    task automatic send_query(int q);
        t_in_word w;
        w = IN_BITS'({$urandom(), $urandom()});
        w.action = ACT_QUERY;
        w.point_index = IDX_BITS'(q);
        send_word(w);
    endtask

    task automatic send_plain(logic [1:0] act);
        t_in_word w;
        w = IN_BITS'({$urandom(), $urandom()});
        w.action = act;
        send_word(w);
    endtask

    // the eight corners of one cell, layer x first, skipping masked and out-of-range ones
    task automatic load_cell(int x, int y, int z, logic [7:0] skip);
        int ord [8] = '{0, 1, 4, 5, 2, 3, 6, 7};
        int cx, cy, cz;
        for (int k = 0; k < 8; k++) begin
            cx = x + (ord[k] >= 2 && ord[k] <= 3 || ord[k] >= 6 ? 1 : 0);
            cy = y + (ord[k] >= 4 ? 1 : 0);
            cz = z + (ord[k] % 2);
            if (!skip[ord[k]] && cx < 1024 && cy < 1024 && cz < 1024)
                send_load(cx, cy, cz);
        end
    endtask

    // idle the block before touching the register
    task automatic write_layers(int v);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (sb.pending_cells.size() == 0);
        repeat (20) @(posedge i_clk);
        cfg_ch.data  <= LC_BITS'(v);
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.layers = v;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int lc_pick [6];
        int x0, y0, z0, nl, ny, nz, lc;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: hexahedron, wedge, range edges, odd actions
        write_layers(2);
        load_cell(0, 5, 5, 8'h00);
        send_query(0);
        send_query(4);
        send_query(7);
        send_plain(ACT_SPARE);
        send_query(4095);
        send_plain(ACT_CLEAR);
        load_cell(0, 0, 0, 8'h0C);
        send_query(0);
        send_query(1);
        write_layers(0);
        send_query(0);
        write_layers(2047);
        send_plain(ACT_CLEAR);
        load_cell(1022, 1023, 1023, 8'h00);
        send_load(1023, 0, 0);
        send_query(0);
        send_query(2);
        send_query(1);
        send_load(1022, 1023, 1023);
        send_query(3);

        while (items_out < 140) begin
            x0 = $urandom_range(0, 1023);
            y0 = $urandom_range(0, 1023);
            z0 = $urandom_range(0, 1023);
            if ($urandom_range(0, 3) == 0) begin
                y0 = 1023 - $urandom_range(0, 1);
                z0 = 1023 - $urandom_range(0, 1);
            end
            nl = $urandom_range(2, 3);
            ny = $urandom_range(1, 3);
            nz = $urandom_range(1, 3);
            lc_pick = '{0, 1, 2047, 1024, x0 + nl, $urandom_range(0, 2047)};
            lc = lc_pick[$urandom_range(0, 9) < 6 ? 4 : $urandom_range(0, 5)];
            calm = ($urandom_range(0, 3) == 0);
            write_layers(lc);
            send_plain(ACT_CLEAR);
            for (int lx = 0; lx < nl; lx++)
                for (int yy = 0; yy <= ny; yy++)
                    for (int zz = 0; zz <= nz; zz++) begin
                        if ($urandom_range(0, 11) != 0) send_load(x0 + lx, y0 + yy, z0 + zz);
                        if ($urandom_range(0, 19) == 0)
                            send_load($urandom(), $urandom(), $urandom());
                        if ($urandom_range(0, 29) == 0) send_load(x0 + lx, y0 + yy, z0 + zz);
                    end
            if ($urandom_range(0, 4) == 0) send_plain(ACT_SPARE);
            if (items_out > 60 && !hold_done) begin
                hold_req  = 1;
                hold_done = 1;
                calm      = 0;
            end
            for (int k = 0; k < 8; k++)
                send_query($urandom_range(0, 7) == 0 ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, sb.stored + 1));
        end
        in_ch.valid <= 1'b0;

        wait (sb.pending_cells.size() == 0);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_cells.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("simulation failed");
        $finish;
    end
endmodule
